>>> src/ltc_pkg.sv
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared types and constants for the luminance tone compressor.
// ----------------------------------------------------------------------------
package ltc_pkg;

    // Rec.709 luminance weights in Q0.16. The three weights sum to one.
    localparam int WEIGHT_SHIFT = 16;
    localparam logic signed [17:0] LUMA_WEIGHT [3] = '{18'sd13933, 18'sd46871, 18'sd4732};

    localparam int STRENGTH_BITS = 17;

    // Channel order within every three-lane bundle.
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef struct packed {
        logic       valid;
        logic [2:0] neg;
    } ltc_ctrl_t;

    // Width of the divisor 2^F + t, where t needs one bit more than a sample.
    function automatic int div_bits(input int sample_bits, input int fraction_bits);
        int widest;
        widest = (fraction_bits > sample_bits + 1) ? fraction_bits : sample_bits + 1;
        return widest + 1;
    endfunction

endpackage

>>> src/ltc_front.sv
// ----------------------------------------------------------------------------
// ltc_front
// Five register stages: luminance products, luminance sum, strength product,
// divisor, and the rounded dividend that seeds the divider.
// ----------------------------------------------------------------------------
module ltc_front #(
    parameter int SAMPLE_BITS   = 24,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic signed [SAMPLE_BITS-1:0]          red_in,
    input  logic signed [SAMPLE_BITS-1:0]          green_in,
    input  logic signed [SAMPLE_BITS-1:0]          blue_in,
    input  logic [ltc_pkg::STRENGTH_BITS-1:0]      strength,
    output ltc_pkg::ltc_ctrl_t                     ctrl_out,
    output logic [ltc_pkg::div_bits(SAMPLE_BITS, FRACTION_BITS)-1:0] divisor_out,
    output logic [2:0][ltc_pkg::div_bits(SAMPLE_BITS, FRACTION_BITS)-1:0] rem_out,
    output logic [2:0][SAMPLE_BITS-1:0]            low_out
);
    import ltc_pkg::*;

    localparam int SW   = SAMPLE_BITS;
    localparam int FW   = FRACTION_BITS;
    localparam int SUMW = SW + 17;
    localparam int PW   = SW + STRENGTH_BITS;
    localparam int TW   = SW + 1;
    localparam int DW   = div_bits(SAMPLE_BITS, FRACTION_BITS);
    localparam int NW   = SW + FW + 1;
    localparam logic signed [SUMW-1:0] SUM_HALF = SUMW'(1) <<< (WEIGHT_SHIFT - 1);
    localparam logic [PW-1:0] PROD_HALF = PW'(1) << (WEIGHT_SHIFT - 1);

    logic signed [SW-1:0] chan [3];

    assign chan[CH_RED]   = red_in;
    assign chan[CH_GREEN] = green_in;
    assign chan[CH_BLUE]  = blue_in;

    // Stage registers
    ltc_ctrl_t              ctrl1_reg, ctrl2_reg, ctrl3_reg, ctrl4_reg, ctrl5_reg;
    ltc_ctrl_t              ctrl1_next;
    logic signed [SUMW-1:0] wprod1_reg [3];
    logic signed [SUMW-1:0] wprod1_next [3];
    logic [SW-1:0]          mag1_reg [3], mag2_reg [3], mag3_reg [3], mag4_reg [3];
    logic [SW-1:0]          mag1_next [3];
    logic [SW-1:0]          lum2_reg, lum2_next;
    logic [PW-1:0]          sprod3_reg, sprod3_next;
    logic [DW-1:0]          div4_reg, div4_next, div5_reg;
    logic [2:0][DW-1:0]     rem5_reg, rem5_next;
    logic [2:0][SW-1:0]     low5_reg, low5_next;

    logic signed [SUMW-1:0] lum_sum;
    logic signed [SUMW-1:0] lum_sum_rnd;
    logic [PW-1:0]          sprod_rnd;
    logic [TW-1:0]          t_val;
    logic [NW-1:0]          dividend [3];

    always_comb
    begin
        ctrl1_next.valid = in_valid;
        for (int c = 0; c < 3; c++)
        begin
            wprod1_next[c]   = chan[c] * LUMA_WEIGHT[c];
            ctrl1_next.neg[c] = chan[c][SW-1];
            mag1_next[c]     = chan[c][SW-1] ? (SW'(0) - SW'(chan[c])) : SW'(chan[c]);
        end
    end

    // A luminance that rounds to zero or below forces the strength product
    // to zero, so the divisor becomes 2^F (one) and the pixel passes unchanged.
    always_comb
    begin
        lum_sum     = wprod1_reg[CH_RED] + wprod1_reg[CH_GREEN] + wprod1_reg[CH_BLUE];
        lum_sum_rnd = lum_sum + SUM_HALF;
        lum2_next   = (lum_sum >= SUM_HALF) ? lum_sum_rnd[WEIGHT_SHIFT +: SW] : '0;
    end

    assign sprod3_next = PW'(strength) * PW'(lum2_reg);

    always_comb
    begin
        sprod_rnd = sprod3_reg + PROD_HALF;
        t_val     = sprod_rnd[WEIGHT_SHIFT +: TW];
        div4_next = (DW'(1) << FW) + DW'(t_val);
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            dividend[c]  = {1'b0, mag4_reg[c], FW'(0)} + NW'(div4_reg >> 1);
            rem5_next[c] = DW'(dividend[c][NW-1:SW]);
            low5_next[c] = dividend[c][SW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
            ctrl3_reg <= '0;
            ctrl4_reg <= '0;
            ctrl5_reg <= '0;
        end
        else if (en)
        begin
            ctrl1_reg <= ctrl1_next;
            ctrl2_reg <= ctrl1_reg;
            ctrl3_reg <= ctrl2_reg;
            ctrl4_reg <= ctrl3_reg;
            ctrl5_reg <= ctrl4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                wprod1_reg[c] <= wprod1_next[c];
                mag1_reg[c]   <= mag1_next[c];
                mag2_reg[c]   <= mag1_reg[c];
                mag3_reg[c]   <= mag2_reg[c];
                mag4_reg[c]   <= mag3_reg[c];
            end
            lum2_reg   <= lum2_next;
            sprod3_reg <= sprod3_next;
            div4_reg   <= div4_next;
            div5_reg   <= div4_reg;
            rem5_reg   <= rem5_next;
            low5_reg   <= low5_next;
        end
    end

    assign ctrl_out    = ctrl5_reg;
    assign divisor_out = div5_reg;
    assign rem_out     = rem5_reg;
    assign low_out     = low5_reg;

endmodule

>>> src/ltc_div_stage.sv
// ----------------------------------------------------------------------------
// ltc_div_stage
// One restoring division step for all three channels, producing one quotient
// bit per channel and registering the partial remainders.
// ----------------------------------------------------------------------------
module ltc_div_stage #(
    parameter int SAMPLE_BITS   = 24,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  ltc_pkg::ltc_ctrl_t                     ctrl_in,
    input  logic [ltc_pkg::div_bits(SAMPLE_BITS, FRACTION_BITS)-1:0] divisor_in,
    input  logic [2:0][ltc_pkg::div_bits(SAMPLE_BITS, FRACTION_BITS)-1:0] rem_in,
    input  logic [2:0][SAMPLE_BITS-1:0]            low_in,
    output ltc_pkg::ltc_ctrl_t                     ctrl_out,
    output logic [ltc_pkg::div_bits(SAMPLE_BITS, FRACTION_BITS)-1:0] divisor_out,
    output logic [2:0][ltc_pkg::div_bits(SAMPLE_BITS, FRACTION_BITS)-1:0] rem_out,
    output logic [2:0][SAMPLE_BITS-1:0]            low_out
);
    import ltc_pkg::*;

    localparam int SW = SAMPLE_BITS;
    localparam int DW = div_bits(SAMPLE_BITS, FRACTION_BITS);

    ltc_ctrl_t          ctrl_reg;
    logic [DW-1:0]      div_reg;
    logic [2:0][DW-1:0] rem_reg, rem_next;
    logic [2:0][SW-1:0] low_reg, low_next;
    logic [DW:0]        trial [3];
    logic [DW:0]        diff [3];
    logic               fits [3];

    // The low word shifts dividend bits out at the top and quotient bits in
    // at the bottom; after the last step it holds the quotient.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            trial[c]    = {rem_in[c], low_in[c][SW-1]};
            diff[c]     = trial[c] - {1'b0, divisor_in};
            fits[c]     = (trial[c] >= {1'b0, divisor_in});
            rem_next[c] = fits[c] ? diff[c][DW-1:0] : trial[c][DW-1:0];
            low_next[c] = {low_in[c][SW-2:0], fits[c]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= divisor_in;
            rem_reg <= rem_next;
            low_reg <= low_next;
        end
    end

    assign ctrl_out    = ctrl_reg;
    assign divisor_out = div_reg;
    assign rem_out     = rem_reg;
    assign low_out     = low_reg;

endmodule

>>> src/luminance_tone_compress.sv
// ----------------------------------------------------------------------------
// luminance_tone_compress: Reinhard luminance tone compressor, one pixel/cycle.
// The pipeline has five front stages, one divider stage per quotient bit,
// and the output register. Throughput is one pixel per cycle; the whole
// pipeline holds while a result waits at the output.
// Reset empties the pipeline and sets tone_strength to zero (pass-through).
// ----------------------------------------------------------------------------
module luminance_tone_compress #(
    parameter int SAMPLE_BITS   = 24,
    parameter int FRACTION_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ltc_pkg::STRENGTH_BITS-1:0] cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [SAMPLE_BITS-1:0]     red_in,
    input  logic signed [SAMPLE_BITS-1:0]     green_in,
    input  logic signed [SAMPLE_BITS-1:0]     blue_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [SAMPLE_BITS-1:0]     red_out,
    output logic signed [SAMPLE_BITS-1:0]     green_out,
    output logic signed [SAMPLE_BITS-1:0]     blue_out
);
    import ltc_pkg::*;

    localparam int SW = SAMPLE_BITS;
    localparam int DW = div_bits(SAMPLE_BITS, FRACTION_BITS);

    logic [STRENGTH_BITS-1:0] tone_strength_reg;
    logic                     pipe_en;

    ltc_ctrl_t          ctrl_chain [SW+1];
    logic [DW-1:0]      div_chain  [SW+1];
    logic [2:0][DW-1:0] rem_chain  [SW+1];
    logic [2:0][SW-1:0] low_chain  [SW+1];

    ltc_ctrl_t          out_ctrl_reg;
    logic [2:0][SW-1:0] out_pix_reg, out_pix_next;

    // Every stage advances together whenever the output register is empty or its result is being taken.
    assign pipe_en  = !out_ctrl_reg.valid || out_ready;
    assign in_ready = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_strength_reg <= '0;
        end
        else if (cfg_we)
        begin
            tone_strength_reg <= cfg_wdata;
        end
    end

    ltc_front #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (pipe_en),
        .in_valid    (in_valid),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .strength    (tone_strength_reg),
        .ctrl_out    (ctrl_chain[0]),
        .divisor_out (div_chain[0]),
        .rem_out     (rem_chain[0]),
        .low_out     (low_chain[0])
    );

    for (genvar i = 0; i < SW; i++)
    begin : g_div
        ltc_div_stage #(
            .SAMPLE_BITS   (SAMPLE_BITS),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_stage (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (pipe_en),
            .ctrl_in     (ctrl_chain[i]),
            .divisor_in  (div_chain[i]),
            .rem_in      (rem_chain[i]),
            .low_in      (low_chain[i]),
            .ctrl_out    (ctrl_chain[i+1]),
            .divisor_out (div_chain[i+1]),
            .rem_out     (rem_chain[i+1]),
            .low_out     (low_chain[i+1])
        );
    end

    // The quotient is a magnitude; negative inputs get their sign back here.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            out_pix_next[c] = ctrl_chain[SW].neg[c] ? (SW'(0) - low_chain[SW][c])
                                                    : low_chain[SW][c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ctrl_reg <= '0;
        end
        else if (pipe_en)
        begin
            out_ctrl_reg <= ctrl_chain[SW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            out_pix_reg <= out_pix_next;
        end
    end

    assign out_valid = out_ctrl_reg.valid;
    assign red_out   = out_pix_reg[CH_RED];
    assign green_out = out_pix_reg[CH_GREEN];
    assign blue_out  = out_pix_reg[CH_BLUE];

endmodule

>>> src/ltc_checker.sv
// ----------------------------------------------------------------------------
// ltc_checker
// Port-level checks on the tone compressor's request flow, bound to the top.
// ----------------------------------------------------------------------------
module ltc_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] red_out,
    input logic [SAMPLE_BITS-1:0] green_out,
    input logic [SAMPLE_BITS-1:0] blue_out
);

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_out)
            && $stable(green_out) && $stable(blue_out))
        else $error("stalled result changed or dropped");

    // With the output register empty nothing may block a new request.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked while output is empty");

    // Back pressure comes only from the output side.
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while output is being drained");

    // Nothing comes out right after reset releases.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present right after reset");

    // A pending request always sees a defined ready.
    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> !$isunknown(in_ready))
        else $error("ready undefined while a request is pending");

endmodule

bind luminance_tone_compress ltc_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_ltc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out)
);
